// File: sv/tbdc_pkg.sv
// shared constants and types for the token bucket daily cap limiter
`timescale 1ns / 1ps

package tbdc_pkg;

    // default width of the time marks
    localparam int TIME_BITS_DEF = 32;

    // length of the daily window in seconds
    localparam int DAY_SECONDS = 24 * 3600;

    // payload and register widths
    localparam int NOW_W    = 32;
    localparam int TOKEN_W  = 16;
    localparam int PERIOD_W = 17;
    localparam int COUNT_W  = 16;
    localparam int REFUSE_W = 32;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // reset values of the configuration registers
    localparam logic [TOKEN_W-1:0]  BURST_RST  = TOKEN_W'(5);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(60);
    localparam logic [COUNT_W-1:0]  LIMIT_RST  = COUNT_W'(50);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST  = 2'd0,
        CFG_PERIOD = 2'd1,
        CFG_LIMIT  = 2'd2
    } cfg_index_t;

    // transaction kinds
    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_CLEAR   = 1'b1
    } kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVIDE,
        ST_REFILL,
        ST_DECIDE
    } state_t;

endpackage

// File: sv/token_bucket_daily_cap_limiter.sv
// token bucket limiter with a rolling daily cap and a bit-serial refill modulo
// sequence: a clear goes from acceptance to the decide state, a request without refill
//   through prep and decide, a request that refills through prep, divide, refill and decide
//   (restoring remainder, one quotient bit per cycle over the elapsed time); a stalled result
//   holds the decide state until the output register is free
// input: the next transaction is taken once the sequencer is back in idle, while the previous
//   result may still sit in the output register
// reset: asynchronous active-low; registers return to burst 5, period 60, limit 50,
//   the bucket holds 5 tokens, both time marks unset, the daily and refusal counts zero
`timescale 1ns / 1ps

module token_bucket_daily_cap_limiter
    import tbdc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [NOW_W-1:0]     now,

    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 granted,
    output logic [TOKEN_W-1:0]   tokens_left,
    output logic [COUNT_W-1:0]   granted_today,
    output logic [REFUSE_W-1:0]  refusal_count
);

    localparam int CNT_W = $clog2(TIME_BITS);
    localparam logic [TIME_BITS-1:0] DAY_T = TIME_BITS'(DAY_SECONDS);

    // configuration registers
    logic [TOKEN_W-1:0]   burst_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [COUNT_W-1:0]   limit_reg;

    // limiter state
    logic [TOKEN_W-1:0]   token_reg,        token_next;
    logic [TIME_BITS-1:0] refill_mark_reg,  refill_mark_next;
    logic [TIME_BITS-1:0] window_start_reg, window_start_next;
    logic [COUNT_W-1:0]   day_reg,          day_next;
    logic [REFUSE_W-1:0]  refused_reg,      refused_next;

    // captured transaction
    logic                 kind_reg;
    logic [TIME_BITS-1:0] t_reg;

    // serial remainder unit
    logic [TIME_BITS-1:0] gap_reg,  gap_next;
    logic [PERIOD_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;

    // sequencer
    state_t               state_reg, state_next;

    // output register
    logic                 out_valid_reg,  out_valid_next;
    logic                 granted_reg,    granted_next;
    logic [TOKEN_W-1:0]   tokens_out_reg, tokens_out_next;
    logic [COUNT_W-1:0]   today_out_reg,  today_out_next;
    logic [REFUSE_W-1:0]  refuse_out_reg, refuse_out_next;

    // handshake terms
    logic                 in_take;
    logic                 out_free;

    // request preparation terms
    logic [TIME_BITS-1:0] rm_eff;
    logic [TIME_BITS-1:0] ws_eff;
    logic [TIME_BITS-1:0] rm_diff;
    logic [TIME_BITS-1:0] ws_diff;
    logic [TIME_BITS-1:0] period_ext;
    logic                 roll;
    logic                 refill_due;

    // remainder step terms
    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W:0]    trial_sub;

    // admission decision
    logic                 admit_ok;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !(out_valid_reg && out_stall);

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg  <= BURST_RST;
            period_reg <= PERIOD_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BURST:  burst_reg  <= cfg_data[TOKEN_W-1:0];
                CFG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // time marks seeded from the request time when unset
    assign rm_eff     = (refill_mark_reg == '0) ? t_reg : refill_mark_reg;
    assign ws_eff     = (window_start_reg == '0) ? t_reg : window_start_reg;
    assign rm_diff    = t_reg - rm_eff;
    assign ws_diff    = t_reg - ws_eff;
    assign period_ext = TIME_BITS'(period_reg);

    // backwards time never rolls or refills
    assign roll       = (t_reg >= ws_eff) && (ws_diff >= DAY_T);
    assign refill_due = (period_reg != '0) && (t_reg >= rm_eff) && (rm_diff >= period_ext);

    // one restoring remainder step, msb of the gap first
    assign trial     = {rem_reg, gap_reg[TIME_BITS-1]};
    assign trial_sub = trial - {1'b0, period_reg};

    assign admit_ok = (day_reg < limit_reg) && (token_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = (kind == KIND_CLEAR) ? ST_DECIDE : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = refill_due ? ST_DIVIDE : ST_DECIDE;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                    state_next = ST_REFILL;
            end
            ST_REFILL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs of the sequencer
    always_comb
    begin
        case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            default: in_stall = 1'b1;
        endcase
    end

    // datapath next values
    always_comb
    begin
        token_next        = token_reg;
        refill_mark_next  = refill_mark_reg;
        window_start_next = window_start_reg;
        day_next          = day_reg;
        refused_next      = refused_reg;
        gap_next          = gap_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        granted_next      = granted_reg;
        tokens_out_next   = tokens_out_reg;
        today_out_next    = today_out_reg;
        refuse_out_next   = refuse_out_reg;

        case (state_reg)
            ST_PREP:
            begin
                // seed marks, roll the daily window, launch the remainder
                refill_mark_next  = rm_eff;
                window_start_next = roll ? t_reg : ws_eff;
                if (roll)
                    day_next = '0;
                gap_next = rm_diff;
                rem_next = '0;
                cnt_next = CNT_W'(TIME_BITS - 1);
            end
            ST_DIVIDE:
            begin
                rem_next = trial_sub[PERIOD_W] ? trial[PERIOD_W-1:0]
                                               : trial_sub[PERIOD_W-1:0];
                gap_next = {gap_reg[TIME_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_REFILL:
            begin
                // advance the mark by whole periods and fill the bucket
                refill_mark_next = t_reg - TIME_BITS'(rem_reg);
                token_next       = burst_reg;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (kind_reg == KIND_CLEAR)
                    begin
                        token_next        = burst_reg;
                        refill_mark_next  = '0;
                        window_start_next = '0;
                        day_next          = '0;
                        refused_next      = '0;
                        granted_next      = 1'b0;
                        tokens_out_next   = burst_reg;
                        today_out_next    = '0;
                        refuse_out_next   = '0;
                    end
                    else if (admit_ok)
                    begin
                        token_next      = token_reg - TOKEN_W'(1);
                        day_next        = day_reg + COUNT_W'(1);
                        granted_next    = 1'b1;
                        tokens_out_next = token_reg - TOKEN_W'(1);
                        today_out_next  = day_reg + COUNT_W'(1);
                        refuse_out_next = refused_reg;
                    end
                    else
                    begin
                        // saturating refusal count
                        if (refused_reg != '1)
                            refused_next = refused_reg + REFUSE_W'(1);
                        granted_next    = 1'b0;
                        tokens_out_next = token_reg;
                        today_out_next  = day_reg;
                        refuse_out_next = (refused_reg != '1) ?
                                          refused_reg + REFUSE_W'(1) : refused_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and limiter state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            token_reg        <= BURST_RST;
            refill_mark_reg  <= '0;
            window_start_reg <= '0;
            day_reg          <= '0;
            refused_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            token_reg        <= token_next;
            refill_mark_reg  <= refill_mark_next;
            window_start_reg <= window_start_next;
            day_reg          <= day_next;
            refused_reg      <= refused_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            t_reg    <= TIME_BITS'(now);
        end
        gap_reg        <= gap_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        granted_reg    <= granted_next;
        tokens_out_reg <= tokens_out_next;
        today_out_reg  <= today_out_next;
        refuse_out_reg <= refuse_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign tokens_left   = tokens_out_reg;
    assign granted_today = today_out_reg;
    assign refusal_count = refuse_out_reg;

endmodule

// File: test/tb_token_bucket_daily_cap_limiter.sv
// self-checking testbench for the token bucket limiter with a rolling daily cap
`timescale 1ns / 1ps

module tb_token_bucket_daily_cap_limiter
    import tbdc_pkg::*;
;

    // run shape
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 48;
    localparam int WATCHDOG_NS     = 500_000;

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // one pending order for the limiter: a transaction or a register write
    typedef struct {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_data;
        kind_t                op;
        logic [NOW_W-1:0]     stamp;
    } command_t;

    // expected output fields of one transaction
    typedef struct packed {
        logic                grant;
        logic [TOKEN_W-1:0]  tokens;
        logic [COUNT_W-1:0]  today;
        logic [REFUSE_W-1:0] refusals;
    } verdict_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BURST;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    kind_t                kind      = KIND_REQUEST;
    logic [NOW_W-1:0]     now       = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 granted;
    logic [TOKEN_W-1:0]   tokens_left;
    logic [COUNT_W-1:0]   granted_today;
    logic [REFUSE_W-1:0]  refusal_count;

    command_t command_q[$];
    verdict_t verdict_q[$];
    int unsigned faults = 0;

    // predictor copy of the registers
    logic [TOKEN_W-1:0]  burst_reg  = BURST_RST;
    logic [PERIOD_W-1:0] period_reg = PERIOD_RST;
    logic [COUNT_W-1:0]  limit_reg  = LIMIT_RST;

    // predictor copy of the limiter state
    logic [TOKEN_W-1:0]  tokens_held   = BURST_RST;
    logic [NOW_W-1:0]    refill_base   = '0;
    logic [NOW_W-1:0]    day_origin    = '0;
    logic [COUNT_W-1:0]  grants_in_day = '0;
    logic [REFUSE_W-1:0] refused_sum   = '0;

    // pacing state of both sides
    int unsigned send_gap   = 0;
    int unsigned settle     = SETTLE_CYCLES;
    logic        send_calm  = 1'b0;
    int unsigned recv_gap   = 0;
    logic        recv_calm  = 1'b0;

    token_bucket_daily_cap_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .now           (now),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .tokens_left   (tokens_left),
        .granted_today (granted_today),
        .refusal_count (refusal_count)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // advance the predicted limiter by one transaction and return its outputs
    function automatic verdict_t bucket_step(input kind_t op, input logic [NOW_W-1:0] t);
        verdict_t         v;
        logic [NOW_W-1:0] gap;
        v.grant = 1'b0;
        if (op == KIND_CLEAR)
        begin
            tokens_held   = burst_reg;
            refill_base   = '0;
            day_origin    = '0;
            grants_in_day = '0;
            refused_sum   = '0;
        end
        else
        begin
            // unset marks start at the request time
            if (refill_base == '0)
                refill_base = t;
            if (day_origin == '0)
                day_origin = t;
            // roll the daily window
            if (t >= day_origin && (t - day_origin) >= NOW_W'(DAY_SECONDS))
            begin
                day_origin    = t;
                grants_in_day = '0;
            end
            // refill after whole periods, mark moves by whole periods
            if (period_reg != '0 && t >= refill_base
                && (t - refill_base) >= NOW_W'(period_reg))
            begin
                gap         = t - refill_base;
                refill_base = t - gap % NOW_W'(period_reg);
                tokens_held = burst_reg;
            end
            // admission decision
            if (grants_in_day >= limit_reg || tokens_held == '0)
            begin
                if (refused_sum != '1)
                    refused_sum = refused_sum + 1'b1;
            end
            else
            begin
                tokens_held   = tokens_held - 1'b1;
                grants_in_day = grants_in_day + 1'b1;
                v.grant       = 1'b1;
            end
        end
        v.tokens   = tokens_held;
        v.today    = grants_in_day;
        v.refusals = refused_sum;
        return v;
    endfunction

    task automatic queue_request(input logic [NOW_W-1:0] t);
        command_t c;
        c.is_write  = 1'b0;
        c.reg_index = CFG_BURST;
        c.reg_data  = '0;
        c.op        = KIND_REQUEST;
        c.stamp     = t;
        command_q.push_back(c);
    endtask

    // the time stamp of a clear is ignored, so it carries noise
    task automatic queue_clear();
        command_t c;
        c.is_write  = 1'b0;
        c.reg_index = CFG_BURST;
        c.reg_data  = '0;
        c.op        = KIND_CLEAR;
        c.stamp     = $urandom();
        command_q.push_back(c);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        command_t c;
        c.is_write  = 1'b1;
        c.reg_index = idx;
        c.reg_data  = data;
        c.op        = KIND_REQUEST;
        c.stamp     = '0;
        command_q.push_back(c);
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            faults++;
        end
    endtask

    // driver: presents queued transactions, writes registers once the limiter is idle
    always @(posedge clk)
    begin : driver
        command_t head;
        logic     hold;
        logic     we;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_we   <= 1'b0;
        end
        else
        begin
            hold = in_valid && in_stall;
            we   = 1'b0;
            // transaction accepted: predict it and draw the gap before the next one
            if (in_valid && !in_stall)
            begin
                verdict_q.push_back(bucket_step(kind, now));
                send_gap = send_calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0)
                    send_calm = !send_calm;
            end
            if (!hold)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (command_q.size() > 0)
                begin
                    head = command_q[0];
                    if (!head.is_write)
                    begin
                        kind <= head.op;
                        now  <= head.stamp;
                        hold = 1'b1;
                        void'(command_q.pop_front());
                    end
                    else if (verdict_q.size() != 0)
                        settle = SETTLE_CYCLES;
                    else if (settle > 0)
                        settle--;
                    else
                    begin
                        // register write, mirrored into the predictor
                        we        = 1'b1;
                        cfg_index <= head.reg_index;
                        cfg_data  <= head.reg_data;
                        case (head.reg_index)
                            CFG_BURST:  burst_reg  = head.reg_data[TOKEN_W-1:0];
                            CFG_PERIOD: period_reg = head.reg_data[PERIOD_W-1:0];
                            CFG_LIMIT:  limit_reg  = head.reg_data[COUNT_W-1:0];
                            default:    ;
                        endcase
                        void'(command_q.pop_front());
                        settle = SETTLE_CYCLES;
                    end
                end
            end
            in_valid <= hold;
            cfg_we   <= we;
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk)
    begin : monitor
        verdict_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t ns: result mismatch, expected none, actual %0d/%0d/%0d/%0d",
                             $time, granted, tokens_left, granted_today, refusal_count);
                    faults++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("granted", 32'(want.grant), 32'(granted));
                    check_field("tokens_left", 32'(want.tokens), 32'(tokens_left));
                    check_field("granted_today", 32'(want.today), 32'(granted_today));
                    check_field("refusal_count", want.refusals, refusal_count);
                end
                recv_gap = recv_calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0)
                    recv_calm = !recv_calm;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        logic [NOW_W-1:0]    clock_s;
        logic [TOKEN_W-1:0]  burst_pick;
        logic [PERIOD_W-1:0] period_pick;
        logic [COUNT_W-1:0]  limit_pick;
        int unsigned         span;
        int unsigned         pick;

        // directed: reset settings, bucket drain, refill edge, time zero, backwards time
        queue_request('0);
        queue_request(32'd100);
        queue_request(32'd100);
        queue_request(32'd100);
        queue_request(32'd100);
        queue_request(32'd100);
        queue_request(32'd159);
        queue_request(32'd160);
        queue_request(32'd40);
        queue_request(32'd86500);
        queue_request('1);
        queue_clear();
        queue_request('1);
        queue_request(32'd7);

        // directed: register extremes, ignored index, shrinking burst without refill
        queue_write(CFG_SPARE, CFG_W'($urandom()));
        queue_write(CFG_LIMIT, '0);
        queue_write(CFG_BURST, CFG_W'(16'hFFFF));
        queue_write(CFG_PERIOD, '0);
        queue_clear();
        queue_request(32'd1000);
        queue_write(CFG_LIMIT, CFG_W'(16'hFFFF));
        queue_request(32'd2000);
        queue_request(32'd5000000);
        queue_write(CFG_BURST, CFG_W'(2));
        queue_request(32'd5000001);
        queue_write(CFG_PERIOD, CFG_W'(DAY_SECONDS));
        queue_request(32'd5086401);
        queue_request(32'd5086401);
        queue_request(32'd5086401);
        queue_clear();

        // random phases, each with its own register settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 4))
                0:       burst_pick = '0;
                1:       burst_pick = TOKEN_W'(1);
                2:       burst_pick = '1;
                default: burst_pick = TOKEN_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 4))
                0:       period_pick = '0;
                1:       period_pick = PERIOD_W'(1);
                2:       period_pick = PERIOD_W'(DAY_SECONDS);
                default: period_pick = PERIOD_W'($urandom_range(2, 200));
            endcase
            case ($urandom_range(0, 4))
                0:       limit_pick = '0;
                1:       limit_pick = COUNT_W'(1);
                2:       limit_pick = '1;
                default: limit_pick = COUNT_W'($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 3) == 0)
                queue_write(CFG_SPARE, CFG_W'($urandom()));
            queue_write(CFG_BURST, CFG_W'(burst_pick));
            queue_write(CFG_PERIOD, CFG_W'(period_pick));
            queue_write(CFG_LIMIT, CFG_W'(limit_pick));
            if ($urandom_range(0, 1) == 0)
                queue_clear();

            // starting time: anywhere, near the wrap point, or small
            case ($urandom_range(0, 2))
                0:       clock_s = $urandom();
                1:       clock_s = 32'hFFFF_0000 + $urandom_range(0, 65535);
                default: clock_s = $urandom_range(1, 1000);
            endcase
            span = (period_pick == '0) ? 90 : period_pick;

            // mostly a running clock, with clears, stray stamps and jumps mixed in
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    queue_clear();
                else if (pick < 10)
                    queue_request($urandom());
                else if (pick < 13)
                    queue_request('0);
                else if (pick < 18)
                    queue_request(clock_s - $urandom_range(1, span));
                else if (pick < 22)
                begin
                    clock_s = clock_s + DAY_SECONDS + $urandom_range(0, span);
                    queue_request(clock_s);
                end
                else
                begin
                    clock_s = clock_s + $urandom_range(0, span + span / 2);
                    queue_request(clock_s);
                end
            end
        end

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every order is sent and every result is in, then drain
        @(negedge clk);
        while (command_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/tbdc_pkg.sv
sv/token_bucket_daily_cap_limiter.sv
test/tb_token_bucket_daily_cap_limiter.sv
